>>> rtl/rectangle_canvas_painter_macros.svh
// Assertion macros shared by the rectangle canvas painter RTL.
// Each macro takes a label, the clock, the reset and the checked expressions.
`ifndef RECTANGLE_CANVAS_PAINTER_MACROS_SVH
`define RECTANGLE_CANVAS_PAINTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RCP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rcp_pkg.sv
// Shared types, codes and helpers for the rectangle canvas painter.
// Used by rcp_front, rcp_queue, rcp_back and the top level; depends on nothing.
package rcp_pkg;

  // Width of the signed integer pixel bounds derived from the Q-format inputs.
  localparam int unsigned CRD_W = 22;

  // Request kinds on the input channel.
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_DRAW  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BAD_SIZE = 2'd1;
  localparam logic [1:0] STAT_OUTSIDE  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WIDTH      = 2'd0;
  localparam logic [1:0] CFG_HEIGHT     = 2'd1;
  localparam logic [1:0] CFG_BACKGROUND = 2'd2;

  // Operation carried out by the back end.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_CLEAR,
    OP_DRAW,
    OP_READ
  } op_t;

  // Configuration register contents.
  typedef struct packed {
    logic [8:0] width;
    logic [8:0] height;
    logic [7:0] background;
  } cfg_t;

  // Classified request as it travels through the queue.
  typedef struct packed {
    op_t                     op;
    logic                    filled;
    logic signed [CRD_W-1:0] col_min;
    logic signed [CRD_W-1:0] col_max;
    logic signed [CRD_W-1:0] row_min;
    logic signed [CRD_W-1:0] row_max;
    logic [7:0]              paint;
    logic [7:0]              read_col;
    logic [7:0]              read_row;
    logic [1:0]              status;
  } cmd_t;

  // Size register as used: zero acts as one, large values saturate.
  function automatic int unsigned active_size(input logic [8:0] v,
                                              input int unsigned max_side);
    int unsigned r;
    r = int'(v);
    if (r < 1) begin
      r = 1;
    end else if (r > max_side) begin
      r = max_side;
    end
    return r;
  endfunction

endpackage

>>> rtl/rcp_front.sv
// Front end of the rectangle canvas painter: configuration registers and
// request classification into integer pixel bounds. Depends on rcp_pkg.
module rcp_front #(
  parameter int unsigned MAX_SIDE  = 256,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         kind,
  input  logic               rect_filled,
  input  logic signed [19:0] rect_x,
  input  logic signed [19:0] rect_y,
  input  logic signed [19:0] rect_w,
  input  logic signed [19:0] rect_h,
  input  logic [7:0]         paint_char,
  input  logic [7:0]         read_col,
  input  logic [7:0]         read_row,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data,
  input  logic               busy,
  input  logic               q_full,
  output logic               push,
  output rcp_pkg::cmd_t      cmd,
  output rcp_pkg::cfg_t      cfg
);

  localparam int unsigned CRD_W = rcp_pkg::CRD_W;
  localparam int unsigned ONE   = 1 << FRAC_BITS;

  logic [8:0] canvas_width;
  logic [8:0] canvas_height;
  logic [7:0] background_char;

  logic signed [CRD_W-1:0] x0_e, y0_e, w_e, h_e;
  logic signed [CRD_W-1:0] x_lo, x_hi, y_lo, y_hi;
  logic                    size_bad;
  logic                    outside;
  int unsigned             w_act, h_act;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width    <= 9'd1;
      canvas_height   <= 9'd1;
      background_char <= 8'd32;
    end else if (cfg_valid) begin
      case (cfg_index)
        rcp_pkg::CFG_WIDTH:      canvas_width    <= cfg_data;
        rcp_pkg::CFG_HEIGHT:     canvas_height   <= cfg_data;
        rcp_pkg::CFG_BACKGROUND: background_char <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = '{width: canvas_width, height: canvas_height,
                 background: background_char};

  // Sign-extend corners and sizes to the bound width.
  assign x0_e = {{(CRD_W-20){rect_x[19]}}, rect_x};
  assign y0_e = {{(CRD_W-20){rect_y[19]}}, rect_y};
  assign w_e  = {{(CRD_W-20){rect_w[19]}}, rect_w};
  assign h_e  = {{(CRD_W-20){rect_h[19]}}, rect_h};

  // Integer bounds: the first pixel at or after the left edge and the last
  // pixel at or before the right edge. A pixel is near an edge exactly when
  // it is the first or last pixel inside on that axis.
  assign x_lo = (x0_e + $signed(CRD_W'(ONE - 1))) >>> FRAC_BITS;
  assign y_lo = (y0_e + $signed(CRD_W'(ONE - 1))) >>> FRAC_BITS;
  assign x_hi = (x0_e + w_e) >>> FRAC_BITS;
  assign y_hi = (y0_e + h_e) >>> FRAC_BITS;

  assign size_bad = rect_w[19] || (rect_w == 20'sd0) || rect_h[19] || (rect_h == 20'sd0);

  // Read bounds against the canvas size in use.
  assign w_act   = rcp_pkg::active_size(canvas_width, MAX_SIDE);
  assign h_act   = rcp_pkg::active_size(canvas_height, MAX_SIDE);
  assign outside = (32'(read_col) >= w_act) || (32'(read_row) >= h_act);

  // Classify the request.
  always_comb begin
    cmd          = '0;
    cmd.op       = rcp_pkg::OP_NONE;
    cmd.filled   = rect_filled;
    cmd.col_min  = x_lo;
    cmd.col_max  = x_hi;
    cmd.row_min  = y_lo;
    cmd.row_max  = y_hi;
    cmd.paint    = paint_char;
    cmd.read_col = read_col;
    cmd.read_row = read_row;
    cmd.status   = rcp_pkg::STAT_OK;
    case (kind)
      rcp_pkg::KIND_CLEAR: begin
        cmd.op = rcp_pkg::OP_CLEAR;
      end
      rcp_pkg::KIND_DRAW: begin
        if (size_bad) begin
          cmd.status = rcp_pkg::STAT_BAD_SIZE;
        end else begin
          cmd.op = rcp_pkg::OP_DRAW;
        end
      end
      rcp_pkg::KIND_READ: begin
        if (outside) begin
          cmd.status = rcp_pkg::STAT_OUTSIDE;
        end else begin
          cmd.op = rcp_pkg::OP_READ;
        end
      end
      default: ;
    endcase
  end

  // Requests are held off while the queue is full or the canvas is clearing.
  assign in_ready = !q_full && !busy;
  assign push     = in_valid && in_ready;

endmodule

>>> rtl/rcp_queue.sv
// Two-entry request queue between the front and back ends.
// Depends on rcp_pkg for the request type.
module rcp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rcp_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output rcp_pkg::cmd_t head
);

  rcp_pkg::cmd_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];

endmodule

>>> rtl/rcp_back.sv
// Back end of the rectangle canvas painter: canvas memory, clearing pass,
// pixel sweep for clear and draw, reads and the result register.
// Depends on rcp_pkg and rectangle_canvas_painter_macros.svh.
`include "rectangle_canvas_painter_macros.svh"

module rcp_back #(
  parameter int unsigned MAX_SIDE = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  rcp_pkg::cfg_t cfg,
  input  logic          q_valid,
  input  rcp_pkg::cmd_t q_head,
  output logic          q_pop,
  output logic          busy,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    status,
  output logic [7:0]    pixel_char
);

  localparam int unsigned CRD_W  = rcp_pkg::CRD_W;
  localparam int unsigned IDX_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int unsigned SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int unsigned ADDR_W = 2 * IDX_W;
  localparam int unsigned DEPTH  = 1 << ADDR_W;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_SWEEP,
    ST_DONE
  } state_t;

  state_t        state;
  logic [ADDR_W-1:0] init_addr;
  logic [IDX_W-1:0]  col;
  logic [IDX_W-1:0]  row;
  rcp_pkg::cmd_t     cur;
  logic [7:0]        rdata;
  logic [7:0]        mem [DEPTH];

  logic [SIDE_W-1:0]       w_act, h_act;
  logic                    col_last, row_last;
  logic signed [CRD_W-1:0] col_s, row_s;
  logic                    in_x, in_y, on_x, on_y, covered;
  logic                    out_free;
  logic                    result_load;
  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_addr;
  logic [7:0]              mem_data;
  logic [ADDR_W-1:0]       rd_addr;

  assign w_act = SIDE_W'(rcp_pkg::active_size(cfg.width, MAX_SIDE));
  assign h_act = SIDE_W'(rcp_pkg::active_size(cfg.height, MAX_SIDE));

  // Sweep position tests.
  assign col_last = (SIDE_W'(col) + SIDE_W'(1)) == w_act;
  assign row_last = (SIDE_W'(row) + SIDE_W'(1)) == h_act;

  // Coverage of the current pixel by the rectangle.
  assign col_s   = $signed(CRD_W'(col));
  assign row_s   = $signed(CRD_W'(row));
  assign in_x    = (col_s >= cur.col_min) && (col_s <= cur.col_max);
  assign in_y    = (row_s >= cur.row_min) && (row_s <= cur.row_max);
  assign on_x    = (col_s == cur.col_min) || (col_s == cur.col_max);
  assign on_y    = (row_s == cur.row_min) || (row_s == cur.row_max);
  assign covered = in_x && in_y && (cur.filled || on_x || on_y);

  assign out_free    = !out_valid || out_ready;
  assign result_load = (state == ST_DONE) && out_free;
  assign q_pop       = (state == ST_IDLE) && q_valid;
  assign busy        = (state == ST_INIT);

  // Memory write port: zero fill after reset, then the pixel sweep.
  always_comb begin
    mem_we   = 1'b0;
    mem_addr = {row, col};
    mem_data = 8'd0;
    case (state)
      ST_INIT: begin
        mem_we   = 1'b1;
        mem_addr = init_addr;
      end
      ST_SWEEP: begin
        mem_we   = (cur.op == rcp_pkg::OP_CLEAR) ||
                   ((cur.op == rcp_pkg::OP_DRAW) && covered);
        mem_data = (cur.op == rcp_pkg::OP_CLEAR) ? cfg.background : cur.paint;
      end
      default: ;
    endcase
  end

  // Read address comes straight from the queue head as it is popped.
  assign rd_addr = {IDX_W'(32'(q_head.read_row)), IDX_W'(32'(q_head.read_col))};

  // Canvas memory with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_data;
    end
    if (q_pop) begin
      rdata <= mem[rd_addr];
    end
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      init_addr <= '0;
      col       <= '0;
      row       <= '0;
      out_valid <= 1'b0;
    end else begin
      // A taken result drops unless a new one is loaded in the same cycle.
      if (out_valid && out_ready && !result_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_INIT: begin
          init_addr <= init_addr + ADDR_W'(1);
          if (&init_addr) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid) begin
            cur <= q_head;
            col <= '0;
            row <= '0;
            if (q_head.op inside {rcp_pkg::OP_CLEAR, rcp_pkg::OP_DRAW}) begin
              state <= ST_SWEEP;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_SWEEP: begin
          if (col_last) begin
            col <= '0;
            if (row_last) begin
              state <= ST_DONE;
            end else begin
              row <= row + IDX_W'(1);
            end
          end else begin
            col <= col + IDX_W'(1);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            status     <= cur.status;
            pixel_char <= (cur.op == rcp_pkg::OP_READ) ? rdata : 8'd0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks on the sequencer.
  `RCP_ASSERT_IMP(a_no_idle_write, clk, rst, (state == ST_IDLE) || (state == ST_DONE),
                  !mem_we, "canvas written outside a sweep")
  `RCP_ASSERT_IMP(a_sweep_in_canvas, clk, rst, state == ST_SWEEP,
                  (SIDE_W'(col) < w_act) && (SIDE_W'(row) < h_act),
                  "sweep left the active canvas")
  `RCP_ASSERT_NXT(a_result_loaded, clk, rst, (state == ST_DONE) && out_free,
                  out_valid && (state == ST_IDLE), "finished request produced no result")
  `RCP_ASSERT_NXT(a_init_quiet, clk, rst, state == ST_INIT,
                  (state == ST_INIT || state == ST_IDLE) && !out_valid,
                  "result raised during the clearing pass")

endmodule

>>> rtl/rectangle_canvas_painter.sv
// Rectangle canvas painter: clear, draw and read requests on a byte canvas.
// Each clear or draw sweeps every pixel of the active canvas before its result is loaded;
// reads and rejected requests skip the sweep. A result waits until the output is free.
// Requests are executed one at a time; the queue holds up to two more while one runs. Reset
// clears control state and then zero-fills the whole canvas memory, 2^(2*clog2(MAX_SIDE))
// entries (65536 by default), with in_ready low.
module rectangle_canvas_painter #(
  parameter int unsigned MAX_SIDE  = 256,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         kind,
  input  logic               rect_filled,
  input  logic signed [19:0] rect_x,
  input  logic signed [19:0] rect_y,
  input  logic signed [19:0] rect_w,
  input  logic signed [19:0] rect_h,
  input  logic [7:0]         paint_char,
  input  logic [7:0]         read_col,
  input  logic [7:0]         read_row,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [7:0]         pixel_char,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data
);

  logic          busy;
  logic          q_full;
  logic          push;
  logic          pop;
  logic          q_valid;
  rcp_pkg::cmd_t cmd;
  rcp_pkg::cmd_t head;
  rcp_pkg::cfg_t cfg;

  // Request intake and classification.
  rcp_front #(
    .MAX_SIDE  (MAX_SIDE),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .rect_filled (rect_filled),
    .rect_x      (rect_x),
    .rect_y      (rect_y),
    .rect_w      (rect_w),
    .rect_h      (rect_h),
    .paint_char  (paint_char),
    .read_col    (read_col),
    .read_row    (read_row),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .busy        (busy),
    .q_full      (q_full),
    .push        (push),
    .cmd         (cmd),
    .cfg         (cfg)
  );

  // Decoupling queue.
  rcp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (cmd),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .head      (head)
  );

  // Canvas and execution.
  rcp_back #(
    .MAX_SIDE (MAX_SIDE)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_head     (head),
    .q_pop      (pop),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .pixel_char (pixel_char)
  );

endmodule

>>> tb/testbench.sv
// Self-checking testbench for rectangle_canvas_painter: clear, draw and read requests.
// Keeps its own canvas and register copy to predict results that the directed table does not fix. Depends on rcp_pkg.
`timescale 1ns / 100ps

module testbench;

  localparam int MAX_SIDE = 256;
  localparam int FRAC_BITS = 8;
  localparam int ONE = 1 << FRAC_BITS;
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam logic [7:0] MARK_CHAR = 8'h52;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int FIRST_RESIZED_ROW = 6;

  // One request on the input channel.
  typedef struct {
    logic [1:0]         kind;
    logic               filled;
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [19:0] w;
    logic signed [19:0] h;
    logic [7:0]         paint;
    logic [7:0]         col;
    logic [7:0]         row;
  } paint_req_t;

  // One result on the output channel.
  typedef struct {
    logic [1:0] st;
    logic [7:0] px;
  } paint_result_t;

  // A row of the directed table; typed rows carry their result.
  typedef struct {
    paint_req_t    req;
    bit            typed;
    paint_result_t res;
  } dir_row_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         kind;
  logic               rect_filled;
  logic signed [19:0] rect_x;
  logic signed [19:0] rect_y;
  logic signed [19:0] rect_w;
  logic signed [19:0] rect_h;
  logic [7:0]         paint_char;
  logic [7:0]         read_col;
  logic [7:0]         read_row;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         status;
  logic [7:0]         pixel_char;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [8:0]         cfg_data;

  // Mirror of the canvas and registers.
  logic [7:0]    canvas_model [MAX_SIDE*MAX_SIDE];
  logic [8:0]    cfg_w;
  logic [8:0]    cfg_h;
  logic [7:0]    cfg_bg;
  paint_result_t pending_results [$];
  dir_row_t      dir_rows [$];
  int            mismatches = 0;
  bit            idle_on = 1'b1;
  bit            hold_req = 1'b0;

  rectangle_canvas_painter #(
    .MAX_SIDE (MAX_SIDE),
    .FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .rect_filled(rect_filled),
    .rect_x     (rect_x),
    .rect_y     (rect_y),
    .rect_w     (rect_w),
    .rect_h     (rect_h),
    .paint_char (paint_char),
    .read_col   (read_col),
    .read_row   (read_row),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .pixel_char (pixel_char),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // A size register as the block uses it: zero acts as one, large values saturate.
  function automatic int span(input logic [8:0] v);
    if (v == 0) begin
      return 1;
    end
    if (v > MAX_SIDE) begin
      return MAX_SIDE;
    end
    return int'(v);
  endfunction

  function automatic bit near_edge(input int p, input int e);
    return (p - e < ONE) && (e - p < ONE);
  endfunction

  // Apply one request to the mirrored canvas and return its result.
  function automatic paint_result_t apply_request(input paint_req_t q);
    paint_result_t res;
    int cols, rows, x0, y0, x1, y1, px, py;
    cols = span(cfg_w);
    rows = span(cfg_h);
    res.st = rcp_pkg::STAT_OK;
    res.px = 8'h00;
    case (q.kind)
      rcp_pkg::KIND_CLEAR: begin
        for (int r = 0; r < rows; r++) begin
          for (int c = 0; c < cols; c++) begin
            canvas_model[r*MAX_SIDE + c] = cfg_bg;
          end
        end
      end
      rcp_pkg::KIND_DRAW: begin
        if (q.w <= 0 || q.h <= 0) begin
          res.st = rcp_pkg::STAT_BAD_SIZE;
        end else begin
          x0 = int'(q.x);
          y0 = int'(q.y);
          x1 = x0 + int'(q.w);
          y1 = y0 + int'(q.h);
          for (int r = 0; r < rows; r++) begin
            py = r * ONE;
            if (py >= y0 && py <= y1) begin
              for (int c = 0; c < cols; c++) begin
                px = c * ONE;
                if (px >= x0 && px <= x1 &&
                    (q.filled || near_edge(px, x0) || near_edge(px, x1) ||
                     near_edge(py, y0) || near_edge(py, y1))) begin
                  canvas_model[r*MAX_SIDE + c] = q.paint;
                end
              end
            end
          end
        end
      end
      rcp_pkg::KIND_READ: begin
        if (q.col >= cols || q.row >= rows) begin
          res.st = rcp_pkg::STAT_OUTSIDE;
        end else begin
          res.px = canvas_model[int'(q.row)*MAX_SIDE + int'(q.col)];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic dir_row_t drow(input logic [1:0] k, input logic f, input int x,
                                    input int y, input int w, input int h,
                                    input logic [7:0] p, input logic [7:0] c,
                                    input logic [7:0] r, input bit typed,
                                    input logic [1:0] st, input logic [7:0] px);
    dir_row_t d;
    d.req.kind = k;
    d.req.filled = f;
    d.req.x = 20'(x);
    d.req.y = 20'(y);
    d.req.w = 20'(w);
    d.req.h = 20'(h);
    d.req.paint = p;
    d.req.col = c;
    d.req.row = r;
    d.typed = typed;
    d.res.st = st;
    d.res.px = px;
    return d;
  endfunction

  // Random request shaped around the current canvas; most are well formed.
  function automatic paint_req_t gen_request(input bit reads_only);
    paint_req_t q;
    int cols, rows, pick;
    cols = span(cfg_w);
    rows = span(cfg_h);
    q.kind = 2'($urandom_range(0, 3));
    q.filled = 1'($urandom);
    q.x = 20'($urandom);
    q.y = 20'($urandom);
    q.w = 20'($urandom);
    q.h = 20'($urandom);
    q.paint = 8'($urandom);
    q.col = 8'($urandom);
    q.row = 8'($urandom);
    pick = int'($urandom_range(0, 99));
    if (pick < 8) begin
      q.kind = rcp_pkg::KIND_CLEAR;
    end else if (pick < 50) begin
      q.kind = rcp_pkg::KIND_DRAW;
      q.x = 20'(int'($urandom_range(0, (cols + 4) * ONE)) - 2 * ONE);
      q.y = 20'(int'($urandom_range(0, (rows + 4) * ONE)) - 2 * ONE);
      case ($urandom_range(0, 9))
        0: q.w = 20'(-int'($urandom_range(0, 4 * ONE)));
        1: q.w = 20'($urandom_range(1, ONE - 1));
        default: q.w = 20'($urandom_range(1, (cols + 2) * ONE));
      endcase
      case ($urandom_range(0, 9))
        0: q.h = 20'(-int'($urandom_range(0, 4 * ONE)));
        1: q.h = 20'($urandom_range(1, ONE - 1));
        default: q.h = 20'($urandom_range(1, (rows + 2) * ONE));
      endcase
    end else if (pick < 90) begin
      q.kind = rcp_pkg::KIND_READ;
      if ($urandom_range(0, 7) != 0) begin
        q.col = 8'($urandom_range(0, (cols < MAX_SIDE) ? cols : MAX_SIDE - 1));
        q.row = 8'($urandom_range(0, (rows < MAX_SIDE) ? rows : MAX_SIDE - 1));
      end
    end
    // On the full canvas, sweeps are too slow to be left to chance.
    if (reads_only && (q.kind == rcp_pkg::KIND_CLEAR ||
                       (q.kind == rcp_pkg::KIND_DRAW && q.w > 0 && q.h > 0))) begin
      q.kind = rcp_pkg::KIND_READ;
    end
    return q;
  endfunction

  // Offer one request and record its expected result once it is taken.
  // Leaves the request valid unless an idle burst follows.
  task automatic offer(input paint_req_t q, input bit typed, input paint_result_t fixed);
    paint_result_t res;
    in_valid <= 1'b1;
    kind <= q.kind;
    rect_filled <= q.filled;
    rect_x <= q.x;
    rect_y <= q.y;
    rect_w <= q.w;
    rect_h <= q.h;
    paint_char <= q.paint;
    read_col <= q.col;
    read_row <= q.row;
    do @(posedge clk); while (!in_ready);
    res = apply_request(q);
    pending_results.push_back(typed ? fixed : res);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
  endtask

  task automatic offer_random(input bit reads_only);
    paint_result_t none;
    none.st = rcp_pkg::STAT_OK;
    none.px = 8'h00;
    offer(gen_request(reads_only), 1'b0, none);
  endtask

  // Stop offering and wait until every result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [8:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      rcp_pkg::CFG_WIDTH: cfg_w = data;
      rcp_pkg::CFG_HEIGHT: cfg_h = data;
      rcp_pkg::CFG_BACKGROUND: cfg_bg = data[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_canvas(input logic [8:0] w, input logic [8:0] h, input logic [7:0] bg);
    set_reg(rcp_pkg::CFG_WIDTH, w);
    set_reg(rcp_pkg::CFG_HEIGHT, h);
    set_reg(rcp_pkg::CFG_BACKGROUND, {1'b0, bg});
  endtask

  // Result sink: random stall bursts, plus one long hold when asked.
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each result taken with the oldest expectation.
  always @(posedge clk) begin : check_result
    paint_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result with nothing expected: status %0d pixel %02h",
                   $realtime, status, pixel_char);
        end
      end else begin
        want = pending_results.pop_front();
        if (status !== want.st || pixel_char !== want.px) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: expected status %0d pixel %02h, got status %0d pixel %02h",
                     $realtime, want.st, want.px, status, pixel_char);
          end
        end
      end
    end
  end

  initial begin
    #16_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  // Main stimulus sequence.
  initial begin : stimulus
    paint_req_t q;
    rst = 1'b1;
    in_valid = 1'b0;
    kind = rcp_pkg::KIND_CLEAR;
    rect_filled = 1'b0;
    rect_x = '0;
    rect_y = '0;
    rect_w = '0;
    rect_h = '0;
    paint_char = '0;
    read_col = '0;
    read_row = '0;
    cfg_valid = 1'b0;
    cfg_index = rcp_pkg::CFG_WIDTH;
    cfg_data = '0;
    cfg_w = 9'd1;
    cfg_h = 9'd1;
    cfg_bg = 8'd32;
    for (int i = 0; i < MAX_SIDE * MAX_SIDE; i++) begin
      canvas_model[i] = 8'h00;
    end

    // Directed table. The first rows run on the one-pixel canvas after reset.
    dir_rows.push_back(drow(rcp_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0,
                            1, rcp_pkg::STAT_OK, 8'h00));
    dir_rows.push_back(drow(rcp_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 255, 255,
                            1, rcp_pkg::STAT_OUTSIDE, 8'h00));
    dir_rows.push_back(drow(rcp_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 1, 0,
                            1, rcp_pkg::STAT_OUTSIDE, 8'h00));
    dir_rows.push_back(drow(KIND_SPARE, 1, $urandom, $urandom, $urandom, $urandom,
                            8'($urandom), 0, 0, 1, rcp_pkg::STAT_OK, 8'h00));
    dir_rows.push_back(drow(rcp_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0,
                            1, rcp_pkg::STAT_OK, 8'h00));
    dir_rows.push_back(drow(rcp_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0,
                            1, rcp_pkg::STAT_OK, 8'd32));
    // The remaining rows run on a 12 by 10 canvas with background 0xFF.
    dir_rows.push_back(drow(rcp_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0,
                            1, rcp_pkg::STAT_OK, 8'h00));
    dir_rows.push_back(drow(rcp_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 11, 9,
                            1, rcp_pkg::STAT_OK, 8'hFF));
    dir_rows.push_back(drow(rcp_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 12, 0,
                            1, rcp_pkg::STAT_OUTSIDE, 8'h00));
    dir_rows.push_back(drow(rcp_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0, 10,
                            1, rcp_pkg::STAT_OUTSIDE, 8'h00));
    dir_rows.push_back(drow(rcp_pkg::KIND_DRAW, 1, 0, 0, 0, ONE, 8'h11, 0, 0,
                            1, rcp_pkg::STAT_BAD_SIZE, 8'h00));
    dir_rows.push_back(drow(rcp_pkg::KIND_DRAW, 1, 0, 0, ONE, -524288, 8'h11, 0, 0,
                            1, rcp_pkg::STAT_BAD_SIZE, 8'h00));
    dir_rows.push_back(drow(rcp_pkg::KIND_DRAW, 0, 0, 0, -1, 5 * ONE, 8'h11, 0, 0,
                            1, rcp_pkg::STAT_BAD_SIZE, 8'h00));
    // Filled rectangle with fractional corners.
    dir_rows.push_back(drow(rcp_pkg::KIND_DRAW, 1, 3 * ONE / 2, ONE / 4, 4 * ONE, 7 * ONE / 2,
                            MARK_CHAR, 0, 0, 0, rcp_pkg::STAT_OK, 8'h00));
    dir_rows.push_back(drow(rcp_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 2, 1,
                            0, rcp_pkg::STAT_OK, 8'h00));
    // Outline: the interior stays, the border is painted.
    dir_rows.push_back(drow(rcp_pkg::KIND_DRAW, 0, 5 * ONE, 2 * ONE, 5 * ONE, 6 * ONE,
                            8'h00, 0, 0, 0, rcp_pkg::STAT_OK, 8'h00));
    dir_rows.push_back(drow(rcp_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 7, 5,
                            0, rcp_pkg::STAT_OK, 8'h00));
    dir_rows.push_back(drow(rcp_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 5, 4,
                            0, rcp_pkg::STAT_OK, 8'h00));
    // A pixel one away from the left and top edges is not part of the outline.
    dir_rows.push_back(drow(rcp_pkg::KIND_DRAW, 0, 0, 0, 4 * ONE, 4 * ONE,
                            8'h7F, 0, 0, 0, rcp_pkg::STAT_OK, 8'h00));
    dir_rows.push_back(drow(rcp_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 1, 1,
                            0, rcp_pkg::STAT_OK, 8'h00));
    // Extremes of the corner and size fields.
    dir_rows.push_back(drow(rcp_pkg::KIND_DRAW, 1, -524288, -524288, 524287, 524287,
                            8'h55, 0, 0, 0, rcp_pkg::STAT_OK, 8'h00));
    dir_rows.push_back(drow(rcp_pkg::KIND_DRAW, 1, 524287, 0, 1, 1, 8'h66, 0, 0,
                            0, rcp_pkg::STAT_OK, 8'h00));
    dir_rows.push_back(drow(rcp_pkg::KIND_DRAW, 1, 0, 0, 524287, 524287,
                            8'hAA, 0, 0, 0, rcp_pkg::STAT_OK, 8'h00));
    dir_rows.push_back(drow(rcp_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 255, 255,
                            1, rcp_pkg::STAT_OUTSIDE, 8'h00));
    dir_rows.push_back(drow(rcp_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0,
                            0, rcp_pkg::STAT_OK, 8'h00));

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < dir_rows.size(); i++) begin
      if (i == FIRST_RESIZED_ROW) begin
        settle();
        set_canvas(9'd12, 9'd10, 8'hFF);
        set_reg(CFG_UNUSED, 9'h1FF);
      end
      offer(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
    end
    settle();

    // Mid-size canvas, idling switched on and off in stretches.
    set_canvas(9'd20, 9'd16, 8'($urandom));
    for (int i = 0; i < 20; i++) begin
      if (i % 10 == 0) begin
        idle_on = ($urandom_range(0, 2) != 0);
      end
      offer_random(1'b0);
    end
    // Long hold on the result side while reads keep coming, so the block backs up.
    idle_on = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 24; i++) begin
      q = gen_request(1'b1);
      q.kind = rcp_pkg::KIND_READ;
      offer(q, 1'b0, '{rcp_pkg::STAT_OK, 8'h00});
    end
    idle_on = 1'b1;
    settle();

    // Width register zero acts as one column; height above the maximum saturates.
    set_canvas(9'd0, 9'h1FF, 8'h00);
    for (int i = 0; i < 10; i++) begin
      offer_random(1'b0);
    end
    settle();

    // Widest canvas, a few rows.
    set_canvas(9'h1FF, 9'd3, 8'($urandom));
    for (int i = 0; i < 8; i++) begin
      offer_random(1'b0);
    end
    settle();

    // Full-size canvas: one clear, one draw, then requests that do not sweep, mostly reads.
    set_canvas(9'd256, 9'd256, 8'hFF);
    q = gen_request(1'b0);
    q.kind = rcp_pkg::KIND_CLEAR;
    offer(q, 1'b0, '{rcp_pkg::STAT_OK, 8'h00});
    q = gen_request(1'b0);
    q.kind = rcp_pkg::KIND_DRAW;
    q.w = 20'($urandom_range(1, 260 * ONE));
    q.h = 20'($urandom_range(1, 260 * ONE));
    offer(q, 1'b0, '{rcp_pkg::STAT_OK, 8'h00});
    for (int i = 0; i < 10; i++) begin
      offer_random(1'b1);
    end
    settle();

    // Closing stretch with no idling on either side.
    set_canvas(9'd9, 9'd7, 8'($urandom));
    idle_on = 1'b0;
    for (int i = 0; i < 12; i++) begin
      offer_random(1'b0);
    end
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
